### sv/bpnf_pkg.sv
// Package for the bad-pixel neighbour fill block.
// Holds the shared types and fixed widths; no dependencies.
package bpnf_pkg;

   localparam int unsigned PIX_W   = 16;
   localparam int unsigned MARK_W  = 2;
   localparam int unsigned SUM_W   = 20;
   localparam int unsigned NUM_W   = 20;
   localparam int unsigned DEN_W   = 5;
   localparam int unsigned CNT_W   = 4;
   localparam int unsigned TOT_W   = 17;
   localparam int unsigned CFG_W   = 9;
   localparam int unsigned NEED_W  = 4;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_RUN   = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_NEED   = 2'd2,
      REG_UNUSED = 2'd3
   } reg_index_type;

   // Mark bit 0 is the bad flag, bit 1 flags a repair pending to the end of a pass.
   typedef struct packed {
      logic              pix_we;
      logic              mark_we;
      logic [PIX_W-1:0]  pix;
      logic [MARK_W-1:0] mark;
   } mem_req_type;

endpackage

### sv/bpnf_frame_mem.sv
// Frame store: sample memory and mark memory sharing one address.
// Depends on bpnf_pkg. Registered read; a read at the address being written returns the old contents.
module bpnf_frame_mem #(
   parameter int unsigned DEPTH = 65536,
   parameter int unsigned AW    = 16
) (
   input  logic                             clock,
   input  logic [AW-1:0]                    addr,
   input  bpnf_pkg::mem_req_type            req,
   output logic [bpnf_pkg::PIX_W-1:0]       rd_pix,
   output logic [bpnf_pkg::MARK_W-1:0]      rd_mark
);
   import bpnf_pkg::*;

   logic [PIX_W-1:0]  pix_mem  [DEPTH];
   logic [MARK_W-1:0] mark_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (req.pix_we) begin
         pix_mem[addr] <= req.pix;
      end
      rd_pix <= pix_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (req.mark_we) begin
         mark_mem[addr] <= req.mark;
      end
      rd_mark <= mark_mem[addr];
   end

endmodule

### sv/bpnf_mean_div.sv
// Restoring divider, one quotient bit per cycle, used for the rounded mean.
// Depends on bpnf_pkg.
module bpnf_mean_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [bpnf_pkg::NUM_W-1:0]     num,
   input  logic [bpnf_pkg::DEN_W-1:0]     den,
   output logic                           done,
   output logic [bpnf_pkg::NUM_W-1:0]     quo
);
   import bpnf_pkg::*;

   localparam int unsigned STEP_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DEN_W:0]    rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DEN_W+1:0]  trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      if (start) begin
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
         step_in = STEP_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {2'b00, den_ff}) begin
            rem_in = (DEN_W+1)'(trial - {2'b00, den_ff});
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = (DEN_W+1)'(trial);
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      step_ff <= step_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

### sv/bad_pixel_neighbour_fill.sv
// Top level of the bad-pixel neighbour fill block: sequencer and output register.
// Depends on bpnf_pkg, bpnf_frame_mem and bpnf_mean_div.
//
// A write or a read first brings its address below the frame store depth by subtracting
// the depth as often as needed. A run makes passes over the interior of the frame
// through the single port of the frame store: a good pixel is only read and checked,
// a bad pixel has its window read and, when it is repaired, waits for the divider,
// and each pass ends with a sweep over the interior pixels that clears the repaired
// marks. A result waits in an output register, so the next word is taken while it is
// unclaimed.
module bad_pixel_neighbour_fill #(
   parameter int unsigned MAX_WIDTH  = 256,
   parameter int unsigned MAX_HEIGHT = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // pixel_address[15:0], pixel_value[31:16]
   input  logic [2:0]  req_tuser,  // operation[1:0], pixel_is_bad[2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // read_value[15:0], fixed_total[32:16], left_total[49:33]
   output logic        rsp_tuser   // read_is_bad
);
   import bpnf_pkg::*;

   localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int unsigned AW    = $clog2(DEPTH);
   localparam int unsigned XW    = (AW > 16) ? AW : 16;
   localparam int unsigned MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int unsigned DW    = $clog2(MAXD + 1);

   typedef enum logic [13:0] {
      S_IDLE   = 14'b00000000000001,
      S_WRAP   = 14'b00000000000010,
      S_RD     = 14'b00000000000100,
      S_RESP   = 14'b00000000001000,
      S_PSTART = 14'b00000000010000,
      S_CRD    = 14'b00000000100000,
      S_CCHK   = 14'b00000001000000,
      S_NBR    = 14'b00000010000000,
      S_DECIDE = 14'b00000100000000,
      S_DIV    = 14'b00001000000000,
      S_ADV    = 14'b00010000000000,
      S_SRD    = 14'b00100000000000,
      S_SCHK   = 14'b01000000000000,
      S_PEND   = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   logic [CFG_W-1:0]  width_cfg_ff, height_cfg_ff;
   logic [NEED_W-1:0] need_cfg_ff;
   logic [DW-1:0]     w_eff, h_eff;
   logic [NEED_W-1:0] need_eff;

   op_type            op_ff, op_in;
   logic [XW-1:0]     addr_ff, addr_in;
   logic [PIX_W-1:0]  wval_ff, wval_in;
   logic              wbad_ff, wbad_in;

   logic [DW-1:0]     col_ff, col_in, row_ff, row_in;
   logic [AW-1:0]     base_ff, base_in;
   logic              sweep_ff, sweep_in;
   logic [1:0]        dr_ff, dr_in, dc_ff, dc_in;
   logic [3:0]        k_ff, k_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [TOT_W-1:0]  fixed_ff, fixed_in, total_ff, total_in, left_ff, left_in;

   logic [PIX_W-1:0]  res_val_ff, res_val_in;
   logic              res_bad_ff, res_bad_in;
   logic [TOT_W-1:0]  res_fix_ff, res_fix_in, res_left_ff, res_left_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]  rsp_val_ff, rsp_val_in;
   logic              rsp_bad_ff, rsp_bad_in;
   logic [TOT_W-1:0]  rsp_fix_ff, rsp_fix_in, rsp_left_ff, rsp_left_in;

   logic [AW-1:0]     mem_addr;
   mem_req_type       mem_req;
   logic [PIX_W-1:0]  rd_pix;
   logic [MARK_W-1:0] rd_mark;

   logic              div_start, div_done;
   logic [NUM_W-1:0]  div_num, div_quo;
   logic [DEN_W-1:0]  div_den;
   logic [SUM_W-1:0]  sum_mag;
   logic [PIX_W-1:0]  mean;

   logic [AW-1:0]     center_addr, nbr_row, nbr_addr;
   logic              last_col, last_row;

   always_comb begin
      if (width_cfg_ff < CFG_W'(3)) begin
         w_eff = DW'(3);
      end else if (32'(width_cfg_ff) > 32'(MAX_WIDTH)) begin
         w_eff = DW'(MAX_WIDTH);
      end else begin
         w_eff = DW'(width_cfg_ff);
      end
      if (height_cfg_ff < CFG_W'(3)) begin
         h_eff = DW'(3);
      end else if (32'(height_cfg_ff) > 32'(MAX_HEIGHT)) begin
         h_eff = DW'(MAX_HEIGHT);
      end else begin
         h_eff = DW'(height_cfg_ff);
      end
      need_eff = (need_cfg_ff == '0) ? NEED_W'(1) : need_cfg_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_cfg_ff  <= CFG_W'(256);
         height_cfg_ff <= CFG_W'(256);
         need_cfg_ff   <= NEED_W'(3);
      end else if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_WIDTH:  width_cfg_ff  <= csr_wdata;
            REG_HEIGHT: height_cfg_ff <= csr_wdata;
            REG_NEED:   need_cfg_ff   <= csr_wdata[NEED_W-1:0];
            default:    ;
         endcase
      end
   end

   assign center_addr = base_ff + AW'(col_ff);
   assign last_col    = (col_ff + DW'(2)) == w_eff;
   assign last_row    = (row_ff + DW'(2)) == h_eff;

   always_comb begin
      case (dr_ff)
         2'd0:    nbr_row = base_ff - AW'(w_eff);
         2'd1:    nbr_row = base_ff;
         default: nbr_row = base_ff + AW'(w_eff);
      endcase
      nbr_addr = nbr_row + AW'(col_ff) + AW'(dc_ff) - AW'(1);
   end

   assign sum_mag = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign div_num = NUM_W'({sum_mag, 1'b0}) + NUM_W'(cnt_ff);
   assign div_den = {cnt_ff, 1'b0};
   assign mean    = sum_ff[SUM_W-1] ? PIX_W'(-div_quo) : PIX_W'(div_quo);

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      wval_in      = wval_ff;
      wbad_in      = wbad_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      base_in      = base_ff;
      sweep_in     = sweep_ff;
      dr_in        = dr_ff;
      dc_in        = dc_ff;
      k_in         = k_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      fixed_in     = fixed_ff;
      total_in     = total_ff;
      left_in      = left_ff;
      res_val_in   = res_val_ff;
      res_bad_in   = res_bad_ff;
      res_fix_in   = res_fix_ff;
      res_left_in  = res_left_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_val_in   = rsp_val_ff;
      rsp_bad_in   = rsp_bad_ff;
      rsp_fix_in   = rsp_fix_ff;
      rsp_left_in  = rsp_left_ff;
      mem_addr     = center_addr;
      mem_req      = '0;
      div_start    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in       = op_type'(req_tuser[1:0]);
               addr_in     = XW'(req_tdata[15:0]);
               wval_in     = req_tdata[31:16];
               wbad_in     = req_tuser[2];
               res_val_in  = '0;
               res_bad_in  = 1'b0;
               res_fix_in  = '0;
               res_left_in = '0;
               case (op_type'(req_tuser[1:0]))
                  OP_WRITE, OP_READ: state_in = S_WRAP;
                  OP_RUN: begin
                     total_in = '0;
                     state_in = S_PSTART;
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_WRAP: begin
            mem_addr = AW'(addr_ff);
            if ({1'b0, addr_ff} >= (XW+1)'(DEPTH)) begin
               addr_in = XW'({1'b0, addr_ff} - (XW+1)'(DEPTH));
            end else if (op_ff == OP_WRITE) begin
               mem_req.pix_we  = 1'b1;
               mem_req.mark_we = 1'b1;
               mem_req.pix     = wval_ff;
               mem_req.mark    = {1'b0, wbad_ff};
               state_in        = S_RESP;
            end else begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            res_val_in = rd_pix;
            res_bad_in = rd_mark[0];
            state_in   = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_val_in   = res_val_ff;
               rsp_bad_in   = res_bad_ff;
               rsp_fix_in   = res_fix_ff;
               rsp_left_in  = res_left_ff;
               state_in     = S_IDLE;
            end
         end
         S_PSTART: begin
            col_in   = DW'(1);
            row_in   = DW'(1);
            base_in  = AW'(w_eff);
            sweep_in = 1'b0;
            fixed_in = '0;
            left_in  = '0;
            state_in = S_CRD;
         end
         S_CRD: begin
            state_in = S_CCHK;
         end
         S_CCHK: begin
            dr_in  = 2'd0;
            dc_in  = 2'd0;
            k_in   = 4'd0;
            sum_in = '0;
            cnt_in = '0;
            state_in = rd_mark[0] ? S_NBR : S_ADV;
         end
         S_NBR: begin
            mem_addr = nbr_addr;
            if (k_ff != 4'd0 && !rd_mark[0]) begin
               sum_in = sum_ff + SUM_W'(signed'(rd_pix));
               cnt_in = cnt_ff + 1'b1;
            end
            k_in = k_ff + 1'b1;
            if (dc_ff == 2'd2) begin
               dc_in = 2'd0;
               dr_in = dr_ff + 1'b1;
            end else begin
               dc_in = dc_ff + 1'b1;
            end
            if (k_ff == 4'd9) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (NEED_W'(cnt_ff) >= need_eff) begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end else begin
               left_in  = left_ff + 1'b1;
               state_in = S_ADV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               mem_req.pix_we  = 1'b1;
               mem_req.mark_we = 1'b1;
               mem_req.pix     = mean;
               mem_req.mark    = 2'b11;
               fixed_in        = fixed_ff + 1'b1;
               state_in        = S_ADV;
            end
         end
         S_SRD: begin
            state_in = S_SCHK;
         end
         S_SCHK: begin
            if (rd_mark[1]) begin
               mem_req.mark_we = 1'b1;
               mem_req.mark    = 2'b00;
            end
            state_in = S_ADV;
         end
         S_ADV: begin
            state_in = sweep_ff ? S_SRD : S_CRD;
            if (last_col) begin
               col_in  = DW'(1);
               row_in  = row_ff + 1'b1;
               base_in = base_ff + AW'(w_eff);
               if (last_row) begin
                  row_in  = DW'(1);
                  base_in = AW'(w_eff);
                  if (sweep_ff) begin
                     state_in = S_PEND;
                  end else begin
                     sweep_in = 1'b1;
                     state_in = S_SRD;
                  end
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         S_PEND: begin
            total_in = total_ff + fixed_ff;
            if (left_ff != '0 && fixed_ff != '0) begin
               state_in = S_PSTART;
            end else begin
               res_fix_in  = total_ff + fixed_ff;
               res_left_in = left_ff;
               state_in    = S_RESP;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      addr_ff     <= addr_in;
      wval_ff     <= wval_in;
      wbad_ff     <= wbad_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      base_ff     <= base_in;
      sweep_ff    <= sweep_in;
      dr_ff       <= dr_in;
      dc_ff       <= dc_in;
      k_ff        <= k_in;
      sum_ff      <= sum_in;
      cnt_ff      <= cnt_in;
      fixed_ff    <= fixed_in;
      total_ff    <= total_in;
      left_ff     <= left_in;
      res_val_ff  <= res_val_in;
      res_bad_ff  <= res_bad_in;
      res_fix_ff  <= res_fix_in;
      res_left_ff <= res_left_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_bad_ff  <= rsp_bad_in;
      rsp_fix_ff  <= rsp_fix_in;
      rsp_left_ff <= rsp_left_in;
   end

   bpnf_frame_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .addr    (mem_addr),
      .req     (mem_req),
      .rd_pix  (rd_pix),
      .rd_mark (rd_mark)
   );

   bpnf_mean_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_left_ff, rsp_fix_ff, rsp_val_ff};
   assign rsp_tuser  = rsp_bad_ff;

endmodule

### test/tb.sv
// Testbench for bad_pixel_neighbour_fill: drives write, run, read and no-op words and
// checks every response against a built-in frame predictor. Depends on bpnf_pkg.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bpnf_pkg::*;

   typedef struct {
      logic signed [15:0] value;
      logic               is_bad;
      logic [16:0]        fixed;
      logic [16:0]        left;
   } resp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = REG_WIDTH;
   logic [8:0]  csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        rsp_tuser;

   resp_type          pending_resp[$];
   logic signed [15:0] pix_mem [0:65535];
   bit                bad_mem [0:65535];
   bit                next_bad [0:65535];
   int unsigned       width_reg = 256, height_reg = 256, need_reg = 3;
   int                error_count = 0, idle_cycles = 0, word_count = 0, run_count = 0;
   int                fixed_seen = 0;
   bit                calm = 1'b0;

   bad_pixel_neighbour_fill u_dut (.*);

   initial forever #4 clock = ~clock;

   always @(negedge clock) rsp_tready <= calm || ($urandom_range(99) >= 29);

   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      resp_type e;
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 3000000) begin
         $display("Timeout waiting for a word");
         $display("Test completed with failures");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_resp.size() == 0) begin
            $display("MISMATCH unexpected response word");
            error_count++;
         end else begin
            e = pending_resp.pop_front();
            if ($signed(rsp_tdata[15:0]) != e.value)
               report_mismatch("read_value", $signed(rsp_tdata[15:0]), e.value);
            if (rsp_tuser != e.is_bad) report_mismatch("read_is_bad", rsp_tuser, e.is_bad);
            if (rsp_tdata[32:16] != e.fixed)
               report_mismatch("fixed_total", rsp_tdata[32:16], e.fixed);
            if (rsp_tdata[49:33] != e.left)
               report_mismatch("left_total", rsp_tdata[49:33], e.left);
            if (rsp_tdata[55:50] != 0) report_mismatch("padding", rsp_tdata[55:50], 0);
         end
      end
   end

   function automatic int signed round_mean(int signed sum, int signed cnt);
      if (sum >= 0) return (2 * sum + cnt) / (2 * cnt);
      return -((2 * (-sum) + cnt) / (2 * cnt));
   endfunction

   function automatic void clean_frame(output int unsigned fixed_total,
                                       output int unsigned left);
      int unsigned w, h, need, fixed, idx, n, good;
      int signed sum;
      w = width_reg < 3 ? 3 : (width_reg > 256 ? 256 : width_reg);
      h = height_reg < 3 ? 3 : (height_reg > 256 ? 256 : height_reg);
      need = need_reg == 0 ? 1 : need_reg;
      fixed_total = 0;
      left = 1;
      fixed = 1;
      while (left != 0 && fixed != 0) begin
         left = 0;
         fixed = 0;
         for (int r = 1; r + 1 < h; r++)
            for (int c = 1; c + 1 < w; c++) next_bad[r * w + c] = bad_mem[r * w + c];
         for (int r = 1; r + 1 < h; r++) begin
            for (int c = 1; c + 1 < w; c++) begin
               idx = r * w + c;
               if (!bad_mem[idx]) continue;
               sum = 0;
               good = 0;
               for (int dr = -1; dr <= 1; dr++)
                  for (int dc = -1; dc <= 1; dc++) begin
                     n = (r + dr) * w + (c + dc);
                     if (!bad_mem[n]) begin
                        sum += pix_mem[n];
                        good++;
                     end
                  end
               if (good >= need) begin
                  pix_mem[idx] = 16'(round_mean(sum, good));
                  next_bad[idx] = 1'b0;
                  fixed++;
               end else begin
                  left++;
               end
            end
         end
         for (int r = 1; r + 1 < h; r++)
            for (int c = 1; c + 1 < w; c++) bad_mem[r * w + c] = next_bad[r * w + c];
         fixed_total += fixed;
      end
   endfunction

   task automatic send_word(op_type op, logic [15:0] addr, logic signed [15:0] value,
                            logic bad);
      resp_type e;
      int unsigned f, l;
      if (!calm && $urandom_range(99) < 29) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {value, addr};
      req_tuser = {bad, op};
      do @(posedge clock); while (!req_tready);
      e = '{0, 0, 0, 0};
      case (op)
         OP_WRITE: begin
            pix_mem[addr] = value;
            bad_mem[addr] = bad;
         end
         OP_RUN: begin
            clean_frame(f, l);
            e.fixed = f[16:0];
            e.left = l[16:0];
            fixed_seen += f;
            run_count++;
         end
         OP_READ: begin
            e.value = pix_mem[addr];
            e.is_bad = bad_mem[addr];
         end
         default: ;
      endcase
      pending_resp.push_back(e);
      word_count++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid = 1'b0;
      while (pending_resp.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic csr_write(reg_index_type idx, logic [8:0] value);
      drain();
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         REG_WIDTH:  width_reg = value;
         REG_HEIGHT: height_reg = value;
         REG_NEED:   need_reg = value[3:0];
         default: ;
      endcase
   endtask

   function automatic logic signed [15:0] pick_value();
      case ($urandom_range(7))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'(int'($urandom_range(6)) - 3);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic int unsigned frame_size();
      int unsigned w, h;
      w = width_reg < 3 ? 3 : (width_reg > 256 ? 256 : width_reg);
      h = height_reg < 3 ? 3 : (height_reg > 256 ? 256 : height_reg);
      return w * h;
   endfunction

   // Fills the whole frame, so that a run never meets an unwritten pixel.
   task automatic fill_frame(int unsigned bad_pct);
      for (int unsigned a = 0; a < frame_size(); a++)
         send_word(OP_WRITE, 16'(a), pick_value(), $urandom_range(99) < bad_pct);
   endtask

   task automatic test_directed();
      csr_write(REG_WIDTH, 9'd3);
      csr_write(REG_HEIGHT, 9'd3);
      csr_write(REG_NEED, 9'd8);
      for (int a = 0; a < 9; a++) send_word(OP_WRITE, 16'(a), 16'sh7fff, a == 4);
      send_word(OP_RUN, 16'd0, 16'sd0, 1'b0);
      send_word(OP_READ, 16'd4, 16'sd0, 1'b0);
      // A half is rounded away from zero: -3 / 2 becomes -2.
      csr_write(REG_NEED, 9'd0);
      for (int a = 0; a < 9; a++) send_word(OP_WRITE, 16'(a), 16'(a == 0 ? -1 : -2), a > 1);
      send_word(OP_RUN, 16'd0, 16'sd0, 1'b0);
      send_word(OP_READ, 16'd4, 16'sd0, 1'b1);
      send_word(OP_WRITE, 16'hffff, 16'sh8000, 1'b1);
      send_word(OP_READ, 16'hffff, 16'sd0, 1'b0);
      send_word(OP_NONE, 16'hffff, 16'sh7fff, 1'b1);
      csr_write(REG_UNUSED, 9'h1ff);
   endtask

   task automatic test_random_frames();
      int unsigned a;
      for (int ph = 0; ph < 12; ph++) begin
         calm = (ph >= 4 && ph < 7);
         csr_write(REG_WIDTH, ph == 0 ? 9'd0 : 9'($urandom_range(7, 3)));
         csr_write(REG_HEIGHT, ph == 1 ? 9'd2 : 9'($urandom_range(7, 3)));
         csr_write(REG_NEED, ph < 8 ? 9'($urandom_range(8, 1)) : 9'($urandom_range(15)));
         fill_frame($urandom_range(60, 10));
         send_word(OP_RUN, 16'd0, 16'sd0, 1'b0);
         repeat (8) begin
            a = $urandom_range(frame_size() - 1);
            send_word(OP_READ, 16'(a), 16'($urandom), 1'($urandom_range(1)));
         end
         if ($urandom_range(3) == 0) send_word(OP_RUN, 16'd0, 16'sd0, 1'b0);
         if ($urandom_range(3) == 0)
            send_word(OP_NONE, 16'($urandom), 16'($urandom), 1'b1);
      end
      calm = 1'b0;
   endtask

   task automatic test_wide_and_tall();
      csr_write(REG_WIDTH, 9'd30);
      csr_write(REG_HEIGHT, 9'd3);
      csr_write(REG_NEED, 9'd1);
      fill_frame(30);
      send_word(OP_RUN, 16'd0, 16'sd0, 1'b0);
      send_word(OP_READ, 16'd45, 16'sd0, 1'b0);
      csr_write(REG_WIDTH, 9'd3);
      csr_write(REG_HEIGHT, 9'd20);
      csr_write(REG_NEED, 9'd15);
      fill_frame(30);
      send_word(OP_RUN, 16'd0, 16'sd0, 1'b0);
      send_word(OP_READ, 16'd59, 16'sd0, 1'b0);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random_frames();
      test_wide_and_tall();
      drain();
      repeat (50) @(posedge clock);
      $display("Sent %0d words including %0d cleaning runs; %0d pixels repaired in total.",
               word_count, run_count, fixed_seen);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
